// ===== src/mdrf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrf_pkg: shared types and constants for the min-fusion top-K block
// Holds the action codes, the command beat passed from the front to the back,
// the command beat passed from the back to the sorting row, and the sentinel.
// ----------------------------------------------------------------------------
package mdrf_pkg;

    // Width of the item id field and of a distance (unsigned Q20.12).
    localparam int unsigned ID_W   = 10;
    localparam int unsigned DIST_W = 32;

    // Width of a result count; K never exceeds 64.
    localparam int unsigned CNT_W = 7;

    // Depth of the command queue between the front and the back.
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QA_W   = 2;

    // Distance of an item that has not been written since start: 1000000.0.
    localparam logic [DIST_W-1:0] SENTINEL_DIST = 32'hF424_0000;

    // Action carried by every input beat.
    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_LIST_A = 2'd1,
        ACT_LIST_B = 2'd2,
        ACT_FINISH = 2'd3
    } t_action;

    // Command beat kept in the queue.
    typedef struct packed {
        t_action           op;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_cmd;

    // Control beat from the table sequencer to the sorting row.
    typedef struct packed {
        logic              clear;
        logic              ins;
        logic              go;
        logic [CNT_W-1:0]  n;
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_sort_cmd;

endpackage

// ===== src/mdrf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrf_front: input classifier
// Accepts input beats, drops list entries whose id lies outside the current
// item count, and pushes everything else into the command queue.
// ----------------------------------------------------------------------------
module mdrf_front
    import mdrf_pkg::*;
#(
    parameter int unsigned CW = 11
) (
    input  logic              i_valid,
    output logic              o_ready,
    input  t_action           i_action,
    input  logic [ID_W-1:0]   i_id,
    input  logic [DIST_W-1:0] i_dist,
    input  logic [CW-1:0]     i_eff_cnt,
    input  logic              i_full,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic [31:0] w_id_ext;
    logic [31:0] w_cnt_ext;
    logic        w_keep;

    assign w_id_ext  = 32'(i_id);
    assign w_cnt_ext = 32'(i_eff_cnt);

    // Start and finish always pass; list entries pass only when in range.
    always_comb begin
        unique case (i_action)
            ACT_START:  w_keep = 1'b1;
            ACT_LIST_A: w_keep = (w_id_ext < w_cnt_ext);
            ACT_LIST_B: w_keep = (w_id_ext < w_cnt_ext);
            ACT_FINISH: w_keep = 1'b1;
            default:    w_keep = 1'b0;
        endcase
    end

    // A beat is taken whenever the queue has room; dropped beats just vanish.
    assign o_ready        = !i_full;
    assign o_push         = i_valid && !i_full && w_keep;
    assign o_cmd.op       = i_action;
    assign o_cmd.id       = i_id;
    assign o_cmd.distance = i_dist;

endmodule

// ===== src/mdrf_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrf_queue: command queue
// A short first-in first-out buffer that lets the front keep taking beats
// while the back is busy with a table update or a finish.
// ----------------------------------------------------------------------------
module mdrf_queue
    import mdrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wptr;
    logic [QA_W-1:0] r_rptr;
    logic [QA_W:0]   r_count;

    assign o_full  = (r_count == (QA_W+1)'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rptr];

    // Storage, written at the tail.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== src/mdrf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrf_back: fused distance table and sequencer
// Owns the distance table memory. Clears it after reset and on start, applies
// list A overwrites and list B minimum updates, and on finish streams the first
// item_count entries into the sorting row, then waits for the results to go.
// ----------------------------------------------------------------------------
module mdrf_back
    import mdrf_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 1024,
    parameter int unsigned AW        = 10,
    parameter int unsigned CW        = 11
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    input  logic [CW-1:0]    i_eff_cnt,
    input  logic [CNT_W-1:0] i_eff_n,
    input  logic             i_sort_busy,
    output t_sort_cmd        o_sort
);

    typedef enum logic [5:0] {
        ST_CLEAR = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_BREAD = 6'b000100,
        ST_SCAN  = 6'b001000,
        ST_DRAIN = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_back_state;

    logic [DIST_W-1:0] r_mem [MAX_ITEMS];

    t_back_state       r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_b_addr, n_b_addr;
    logic [DIST_W-1:0] r_b_dist, n_b_dist;
    logic [DIST_W-1:0] r_rd_data;
    logic              r_rd_v, n_rd_v;
    logic [ID_W-1:0]   r_rd_idx, n_rd_idx;

    logic              w_wr_en;
    logic [AW-1:0]     w_wr_addr;
    logic [DIST_W-1:0] w_wr_data;
    logic              w_rd_en;
    logic [AW-1:0]     w_rd_addr;
    logic              w_sort_clear;
    logic              w_sort_go;
    logic [31:0]       w_cmd_ext;
    logic [31:0]       w_idx_ext;
    logic [AW-1:0]     w_cmd_addr;

    assign w_cmd_ext  = 32'(i_cmd.id);
    assign w_idx_ext  = 32'(r_idx);
    assign w_cmd_addr = w_cmd_ext[AW-1:0];

    // Sequencer: one command at a time from the queue.
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_b_addr     = r_b_addr;
        n_b_dist     = r_b_dist;
        n_rd_v       = 1'b0;
        n_rd_idx     = r_rd_idx;
        o_pop        = 1'b0;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_idx[AW-1:0];
        w_wr_data    = SENTINEL_DIST;
        w_rd_en      = 1'b0;
        w_rd_addr    = r_idx[AW-1:0];
        w_sort_clear = 1'b0;
        w_sort_go    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                w_wr_en = 1'b1;
                if (r_idx == CW'(MAX_ITEMS - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    unique case (i_cmd.op)
                        ACT_START: begin
                            n_idx   = '0;
                            n_state = ST_CLEAR;
                        end
                        ACT_LIST_A: begin
                            w_wr_en   = 1'b1;
                            w_wr_addr = w_cmd_addr;
                            w_wr_data = i_cmd.distance;
                        end
                        ACT_LIST_B: begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_cmd_addr;
                            n_b_addr  = w_cmd_addr;
                            n_b_dist  = i_cmd.distance;
                            n_state   = ST_BREAD;
                        end
                        ACT_FINISH: begin
                            w_sort_clear = 1'b1;
                            n_idx        = '0;
                            n_state      = ST_SCAN;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_BREAD: begin
                // Stored value is back from the memory; keep the smaller one.
                if (r_b_dist < r_rd_data) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_b_addr;
                    w_wr_data = r_b_dist;
                end
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                w_rd_en  = 1'b1;
                n_rd_v   = 1'b1;
                n_rd_idx = w_idx_ext[ID_W-1:0];
                if (r_idx == i_eff_cnt - 1'b1) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_DRAIN: begin
                // Last entry enters the row now; emission starts next cycle.
                w_sort_go = 1'b1;
                n_state   = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_sort_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Control state; reset starts the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rd_v  <= n_rd_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_b_addr <= n_b_addr;
        r_b_dist <= n_b_dist;
        r_rd_idx <= n_rd_idx;
    end

    assign o_sort.clear    = w_sort_clear;
    assign o_sort.ins      = r_rd_v;
    assign o_sort.go       = w_sort_go;
    assign o_sort.n        = i_eff_n;
    assign o_sort.id       = r_rd_idx;
    assign o_sort.distance = r_rd_data;

endmodule

// ===== src/mdrf_topk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mdrf_topk: insertion sorting row and result emitter
// A row of cells kept in ascending distance order. Each inserted entry lands
// ahead of the first cell holding a larger distance, so equal distances keep
// scan order. On go the row is shifted out through an output register.
// ----------------------------------------------------------------------------
module mdrf_topk
    import mdrf_pkg::*;
#(
    parameter int unsigned MAX_K = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_sort_cmd         i_cmd,
    output logic              o_busy,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ID_W-1:0]   o_id,
    output logic [DIST_W-1:0] o_dist,
    output logic              o_last
);

    logic [DIST_W-1:0] r_dist [MAX_K];
    logic [ID_W-1:0]   r_id   [MAX_K];
    logic [MAX_K-1:0]  r_vld;
    logic [CNT_W-1:0]  r_left;
    logic              r_out_valid;
    logic [ID_W-1:0]   r_out_id;
    logic [DIST_W-1:0] r_out_dist;
    logic              r_out_last;

    logic [MAX_K-1:0]  w_lt;
    logic [MAX_K-1:0]  w_prev_lt;
    logic [MAX_K-1:0]  w_prev_vld;
    logic [MAX_K-1:0]  w_nxt_vld;
    logic [DIST_W-1:0] w_prev_dist [MAX_K];
    logic [ID_W-1:0]   w_prev_id   [MAX_K];
    logic [DIST_W-1:0] w_nxt_dist  [MAX_K];
    logic [ID_W-1:0]   w_nxt_id    [MAX_K];
    logic              w_emit;

    // Neighbor views of each cell: the one before for insertion, the one
    // after for shifting out.
    for (genvar g = 0; g < MAX_K; g++) begin : g_cell
        assign w_lt[g] = !r_vld[g] || (i_cmd.distance < r_dist[g]);
        if (g == 0) begin : g_head
            assign w_prev_lt[g]   = 1'b0;
            assign w_prev_vld[g]  = 1'b1;
            assign w_prev_dist[g] = i_cmd.distance;
            assign w_prev_id[g]   = i_cmd.id;
        end else begin : g_body
            assign w_prev_lt[g]   = w_lt[g-1];
            assign w_prev_vld[g]  = r_vld[g-1];
            assign w_prev_dist[g] = r_dist[g-1];
            assign w_prev_id[g]   = r_id[g-1];
        end
        if (g == MAX_K - 1) begin : g_tail
            assign w_nxt_vld[g]  = 1'b0;
            assign w_nxt_dist[g] = r_dist[g];
            assign w_nxt_id[g]   = r_id[g];
        end else begin : g_inner
            assign w_nxt_vld[g]  = r_vld[g+1];
            assign w_nxt_dist[g] = r_dist[g+1];
            assign w_nxt_id[g]   = r_id[g+1];
        end
    end

    assign w_emit = (r_left != '0) && (!r_out_valid || i_ready);

    // Cell payload: insert from the neighbor before, or shift from the one after.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_K; j++) begin
            if (i_cmd.ins) begin
                if (w_lt[j]) begin
                    r_dist[j] <= w_prev_lt[j] ? w_prev_dist[j] : i_cmd.distance;
                    r_id[j]   <= w_prev_lt[j] ? w_prev_id[j]   : i_cmd.id;
                end
            end else if (w_emit) begin
                r_dist[j] <= w_nxt_dist[j];
                r_id[j]   <= w_nxt_id[j];
            end
        end
    end

    // Cell valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_cmd.clear) begin
            r_vld <= '0;
        end else begin
            for (int j = 0; j < MAX_K; j++) begin
                if (i_cmd.ins) begin
                    if (w_lt[j]) begin
                        r_vld[j] <= w_prev_lt[j] ? w_prev_vld[j] : 1'b1;
                    end
                end else if (w_emit) begin
                    r_vld[j] <= w_nxt_vld[j];
                end
            end
        end
    end

    // Emission count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.go) begin
                r_left <= i_cmd.n;
            end else if (w_emit) begin
                r_left <= r_left - 1'b1;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload, loaded from the head cell.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_id   <= r_id[0];
            r_out_dist <= r_dist[0];
            r_out_last <= (r_left == CNT_W'(1));
        end
    end

    assign o_busy  = (r_left != '0) || r_out_valid;
    assign o_valid = r_out_valid;
    assign o_id    = r_out_id;
    assign o_dist  = r_out_dist;
    assign o_last  = r_out_last;

    // Entries never enter the row while results are still going out.
    a_no_ins_while_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> (r_left == '0) && !r_out_valid)
        else $error("sorting row insert during emission");

    // The final result of a run leaves nothing behind.
    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (r_left == '0))
        else $error("last mark with results still pending");

    // A start of emission always has at least one result to give.
    a_go_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.go |=> (r_left != '0))
        else $error("emission started with no results");

    // The two head cells stay in ascending order.
    if (MAX_K > 1) begin : g_order_chk
        a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            r_vld[1] |-> r_vld[0] && !(r_dist[1] < r_dist[0]))
            else $error("sorting row out of order");
    end

endmodule

// ===== src/min_distance_rank_fusion_topk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_distance_rank_fusion_topk: min-fusion top-K selection
// Fuses two rankings into one minimum distance per item and emits the K
// items of least distance in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//  Input stream s_axis: tuser carries the action (start, list A entry, list B
//  entry, finish), tdata the item id and distance. Output stream m_axis gives
//  one beat per ranked result, lowest distance first, tlast on the final one.
//  The configuration channel writes k_results (index 0) and item_count
//  (index 1) and is always ready; the user must write only while the block is
//  idle, which the block itself does not enforce. Sequencing: a list A beat
//  is applied from the idle state, a list B beat takes a read, then a compare
//  and write. Start rewrites every table entry. Finish reads item_count
//  entries one per cycle through the single table read port, then emits
//  min(K, count) beats, one per cycle while m_axis_tready stays high. A
//  4-deep command queue lets input beats arrive while the sequencer is busy.
//  Reset: the table is cleared to the sentinel distance by a clearing pass
//  over every entry; input beats are queued but not applied until it ends.
//  A stalled receiver holds the current result in the output register and
//  pauses emission; later commands wait in the queue.
// ----------------------------------------------------------------------------
module min_distance_rank_fusion_topk
    import mdrf_pkg::*;
#(
    parameter int unsigned MAX_ITEMS = 1024,
    parameter int unsigned MAX_K     = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [10:0] i_cfg_data,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // [9:0] item_id, [41:10] distance, rest zero
    input  logic [1:0]  s_axis_tuser,  // [1:0] action
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // [9:0] out_id, [41:10] out_distance, rest zero
    output logic        m_axis_tlast
);

    localparam int unsigned AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    localparam logic [1:0] REG_K_RESULTS  = 2'd0;
    localparam logic [1:0] REG_ITEM_COUNT = 2'd1;

    logic [6:0]       r_k_results;
    logic [10:0]      r_item_count;

    logic [31:0]      w_cnt_ext;
    logic [31:0]      w_cnt_sel;
    logic [31:0]      w_k_ext;
    logic [31:0]      w_k_cap;
    logic [31:0]      w_k_sel;
    logic [CW-1:0]    w_eff_cnt;
    logic [CNT_W-1:0] w_eff_n;

    logic             w_push;
    t_cmd             w_push_cmd;
    logic             w_full;
    logic             w_pop;
    logic             w_empty;
    t_cmd             w_head;
    t_sort_cmd        w_sort;
    logic             w_sort_busy;
    logic [ID_W-1:0]  w_out_id;
    logic [DIST_W-1:0] w_out_dist;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_results  <= 7'd10;
            r_item_count <= 11'd1024;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_K_RESULTS) begin
                r_k_results <= i_cfg_data[6:0];
            end else if (i_cfg_index == REG_ITEM_COUNT) begin
                r_item_count <= i_cfg_data;
            end
        end
    end

    // Effective item count and result count, clamped to their ranges.
    assign w_cnt_ext = 32'(r_item_count);
    assign w_cnt_sel = (w_cnt_ext == 32'd0)             ? 32'd1 :
                       (w_cnt_ext > 32'(MAX_ITEMS))     ? 32'(MAX_ITEMS) : w_cnt_ext;
    assign w_k_ext   = 32'(r_k_results);
    assign w_k_cap   = (w_k_ext == 32'd0)               ? 32'd1 :
                       (w_k_ext > 32'(MAX_K))           ? 32'(MAX_K) : w_k_ext;
    assign w_k_sel   = (w_k_cap > w_cnt_sel) ? w_cnt_sel : w_k_cap;
    assign w_eff_cnt = w_cnt_sel[CW-1:0];
    assign w_eff_n   = w_k_sel[CNT_W-1:0];

    mdrf_front #(
        .CW (CW)
    ) u_front (
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_action  (t_action'(s_axis_tuser)),
        .i_id      (s_axis_tdata[9:0]),
        .i_dist    (s_axis_tdata[41:10]),
        .i_eff_cnt (w_eff_cnt),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_cmd     (w_push_cmd)
    );

    mdrf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    mdrf_back #(
        .MAX_ITEMS (MAX_ITEMS),
        .AW        (AW),
        .CW        (CW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_cmd       (w_head),
        .o_pop       (w_pop),
        .i_eff_cnt   (w_eff_cnt),
        .i_eff_n     (w_eff_n),
        .i_sort_busy (w_sort_busy),
        .o_sort      (w_sort)
    );

    mdrf_topk #(
        .MAX_K (MAX_K)
    ) u_topk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_sort),
        .o_busy  (w_sort_busy),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_id    (w_out_id),
        .o_dist  (w_out_dist),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, w_out_dist, w_out_id};

endmodule

// ===== tb/min_distance_rank_fusion_topk_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_distance_rank_fusion_topk_tb: self-checking bench for min-fusion top-K
// Streams start, list A, list B and finish commands into the block. It
// reprograms K and the item count between runs and stalls both stream sides
// at random. A scoreboard keeps its own fused-distance table and expects, at
// every finish, the best entries in distance order with ties to the lower id.
// ----------------------------------------------------------------------------
module min_distance_rank_fusion_topk_tb;
    import mdrf_pkg::*;

    localparam int unsigned CLK_PERIOD    = 10;
    localparam int unsigned RESET_CYCLES  = 11;
    localparam int unsigned TABLE_DEPTH   = 1024;
    localparam int unsigned TOPK_MAX      = 64;
    localparam int unsigned RANDOM_ITEMS  = 300;
    // Four queued starts plus the one in progress, with some margin.
    localparam int unsigned SETTLE_CYCLES = 5 * TABLE_DEPTH + 64;
    localparam int unsigned STALL_LIMIT   = 40000;

    // Configuration register indexes.
    localparam logic [1:0] REG_K_RESULTS  = 2'd0;
    localparam logic [1:0] REG_ITEM_COUNT = 2'd1;
    localparam logic [1:0] REG_SPARE_2    = 2'd2;
    localparam logic [1:0] REG_SPARE_3    = 2'd3;

    localparam logic [6:0]  K_RESET     = 7'd10;
    localparam logic [10:0] COUNT_RESET = 11'd1024;

    // One ranked result beat.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
        logic              last;
    } t_rank_beat;

    // Tracks the fused table and the ranked beats still owed by the block.
    class rank_fusion_scoreboard;
        logic [DIST_W-1:0] fused [TABLE_DEPTH];
        logic [6:0]        k_reg;
        logic [10:0]       count_reg;
        t_rank_beat        expected_ranks [$];
        int unsigned       errors;

        function new();
            foreach (fused[i]) fused[i] = SENTINEL_DIST;
            k_reg     = K_RESET;
            count_reg = COUNT_RESET;
            errors    = 0;
        endfunction

        // Item count as the block applies it: zero acts as one, saturates high.
        function int unsigned eff_count();
            if (count_reg == 0) return 1;
            if (count_reg > TABLE_DEPTH) return TABLE_DEPTH;
            return count_reg;
        endfunction

        function void set_reg(logic [1:0] idx, logic [10:0] data);
            case (idx)
                REG_K_RESULTS:  k_reg = data[6:0];
                REG_ITEM_COUNT: count_reg = data;
                default: ;
            endcase
        endfunction

        function bit pending();
            return expected_ranks.size() != 0;
        endfunction

        // Applies one accepted command; a finish queues its ranked beats.
        function void note_command(t_action act, logic [ID_W-1:0] id,
                                   logic [DIST_W-1:0] distance);
            bit          taken [TABLE_DEPTH];
            int unsigned cnt, k, pick;
            t_rank_beat  beat;
            cnt = eff_count();
            case (act)
                ACT_START: begin
                    foreach (fused[i]) fused[i] = SENTINEL_DIST;
                end
                ACT_LIST_A: begin
                    if (id < cnt) fused[id] = distance;
                end
                ACT_LIST_B: begin
                    if (id < cnt && distance < fused[id]) fused[id] = distance;
                end
                ACT_FINISH: begin
                    k = (k_reg == 0) ? 1 : k_reg;
                    if (k > TOPK_MAX) k = TOPK_MAX;
                    if (k > cnt) k = cnt;
                    foreach (taken[i]) taken[i] = 1'b0;
                    // Repeated selection of the minimum; the ascending scan with a
                    // strict compare keeps the lower id first on equal distances.
                    for (int unsigned r = 0; r < k; r++) begin
                        pick = cnt;
                        for (int unsigned i = 0; i < cnt; i++) begin
                            if (!taken[i] && (pick == cnt || fused[i] < fused[pick]))
                                pick = i;
                        end
                        taken[pick] = 1'b1;
                        beat.id       = ID_W'(pick);
                        beat.distance = fused[pick];
                        beat.last     = (r + 1 == k);
                        expected_ranks = {expected_ranks, beat};
                    end
                end
                default: ;
            endcase
        endfunction

        // Compares one accepted result beat with the oldest expectation.
        function void check_rank_beat(logic [ID_W-1:0] id, logic [DIST_W-1:0] distance,
                                      logic last);
            t_rank_beat want;
            if (expected_ranks.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual id %0d dist %h last %b",
                         $time, id, distance, last);
                errors++;
                return;
            end
            want = expected_ranks.pop_front();
            if (id !== want.id) begin
                $display("%0t: out_id mismatch: expected %0d, actual %0d",
                         $time, want.id, id);
                errors++;
            end
            if (distance !== want.distance) begin
                $display("%0t: out_distance mismatch: expected %h, actual %h",
                         $time, want.distance, distance);
                errors++;
            end
            if (last !== want.last) begin
                $display("%0t: tlast mismatch: expected %b, actual %b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function void check_drained();
            if (expected_ranks.size() != 0) begin
                $display("%0t: results missing: expected %0d more, actual 0",
                         $time, expected_ranks.size());
                errors++;
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index   = '0;
    logic [10:0] i_cfg_data    = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;  // [9:0] item_id, [41:10] distance, rest zero
    logic [1:0]  s_axis_tuser  = '0;  // [1:0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // [9:0] out_id, [41:10] out_distance, rest zero
    logic        m_axis_tlast;

    rank_fusion_scoreboard sb = new();

    int unsigned send_idle_pct = 9;
    int unsigned recv_idle_pct = 70;
    int unsigned stall_cycles  = 0;
    int unsigned fed_items     = 0;

    // Corner settings visited first in the random part.
    int unsigned corner_k   [6] = '{64, 1, 127, 0, 64, 5};
    int unsigned corner_cnt [6] = '{1024, 2047, 64, 0, 3, 1};

    min_distance_rank_fusion_topk i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Results and progress are sampled mid-cycle, away from the driving edge.
    always @(negedge i_clk) begin : watch_outputs
        logic moved;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready)
                sb.check_rank_beat(m_axis_tdata[ID_W-1:0],
                                   m_axis_tdata[ID_W+DIST_W-1:ID_W], m_axis_tlast);
            moved = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready);
            if (moved || !(s_axis_tvalid || i_cfg_valid || sb.pending()))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat accepted for %0d cycles", $time, stall_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Distances biased toward the extremes, the sentinel and a few tied values.
    function automatic logic [DIST_W-1:0] pick_dist();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SENTINEL_DIST;
            3:       return SENTINEL_DIST - 32'd1;
            4:       return SENTINEL_DIST + 32'd1;
            5, 6:    return DIST_W'($urandom_range(0, 7)) << 12;
            default: return $urandom;
        endcase
    endfunction

    // Sends one command beat after an optional random gap.
    task automatic send_command(input t_action act, input logic [ID_W-1:0] id,
                                input logic [DIST_W-1:0] distance);
        int unsigned gap;
        logic        fire;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, distance, id};
        s_axis_tuser  <= act;
        fire = 1'b0;
        while (!fire) begin
            @(negedge i_clk);
            fire = s_axis_tready;
            @(posedge i_clk);
        end
        sb.note_command(act, id, distance);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
        logic fire;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        fire = 1'b0;
        while (!fire) begin
            @(negedge i_clk);
            fire = o_cfg_ready;
            @(posedge i_clk);
        end
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Holds the sender until every owed result has been accepted.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending());
    endtask

    // New settings only once the block has gone quiet.
    task automatic reconfigure(input logic [10:0] k_data, input logic [10:0] count_data);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_K_RESULTS, k_data);
        write_reg(REG_ITEM_COUNT, count_data);
    endtask

    // One fusion run: start, list A, list B, some noise, then finish.
    task automatic ranking_round();
        int unsigned cnt, n_list, j, tmp, noise;
        int unsigned order [16];
        t_action     act;
        logic [ID_W-1:0] id;
        cnt = sb.eff_count();
        send_command(ACT_START, ID_W'($urandom), $urandom);
        fed_items++;
        for (int unsigned pass = 0; pass < 2; pass++) begin
            act = (pass == 0) ? ACT_LIST_A : ACT_LIST_B;
            // Small tables get cnt entries with distinct ids, a shuffled pick from 0 to 15.
            n_list = (cnt <= 16) ? cnt : $urandom_range(1, 16);
            for (int unsigned i = 0; i < 16; i++) order[i] = i;
            for (int unsigned i = 15; i > 0; i--) begin
                j        = $urandom_range(0, i);
                tmp      = order[i];
                order[i] = order[j];
                order[j] = tmp;
            end
            for (int unsigned i = 0; i < n_list; i++) begin
                id = (cnt <= 16) ? ID_W'(order[i]) : ID_W'($urandom_range(0, cnt - 1));
                send_command(act, id, pick_dist());
                fed_items++;
            end
        end
        // Noise: ids past the item count and the odd misplaced command.
        noise = $urandom_range(0, 3);
        repeat (noise) begin
            if ($urandom_range(0, 7) == 0) act = t_action'($urandom_range(0, 3));
            else act = t_action'($urandom_range(1, 2));
            if (cnt < TABLE_DEPTH && $urandom_range(0, 1) == 1)
                id = ID_W'($urandom_range(cnt, TABLE_DEPTH - 1));
            else
                id = ID_W'($urandom);
            send_command(act, id, $urandom);
        end
        send_command(ACT_FINISH, ID_W'($urandom), $urandom);
        fed_items++;
        if ($urandom_range(0, 3) == 0) send_command(ACT_FINISH, ID_W'($urandom), $urandom);
        if ($urandom_range(0, 2) == 0) drain_results();
    endtask

    initial begin : stimulus
        int unsigned phase;
        logic [10:0] k_data, count_data;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset settings.
        send_command(ACT_FINISH, '0, '0);
        send_command(ACT_START, '1, '1);
        send_command(ACT_LIST_A, 10'd0, 32'd0);
        send_command(ACT_LIST_A, 10'd1023, 32'hFFFF_FFFF);
        send_command(ACT_LIST_A, 10'd5, SENTINEL_DIST);
        send_command(ACT_LIST_B, 10'd0, 32'd5);
        send_command(ACT_LIST_B, 10'd7, 32'hFFFF_FFFF);
        send_command(ACT_LIST_B, 10'd3, 32'd100);
        send_command(ACT_LIST_A, 10'd9, 32'd100);
        send_command(ACT_LIST_A, 10'd3, 32'd200);
        send_command(ACT_LIST_B, 10'd3, 32'd200);
        send_command(ACT_LIST_B, 10'd9, 32'd99);
        send_command(ACT_FINISH, '0, '0);
        send_command(ACT_FINISH, '1, '1);
        // K above its maximum, four items, and writes to indexes with no register.
        reconfigure(11'd127, 11'd4);
        write_reg(REG_SPARE_2, 11'($urandom));
        write_reg(REG_SPARE_3, 11'($urandom));
        send_command(ACT_LIST_A, 10'd4, 32'd1);
        send_command(ACT_LIST_B, 10'd1023, 32'd0);
        send_command(ACT_LIST_A, 10'd2, 32'd1);
        send_command(ACT_FINISH, '0, '0);
        // Zero K and zero count both act as one.
        reconfigure(11'd0, 11'd0);
        send_command(ACT_LIST_A, 10'd1, 32'd0);
        send_command(ACT_FINISH, '0, '0);
        send_command(ACT_START, '0, '0);
        send_command(ACT_FINISH, '0, '0);
        // Count above the table depth saturates; all sixty-four sentinels come out.
        reconfigure(11'd64, 11'd2047);
        send_command(ACT_FINISH, '0, '0);

        // Random runs: corner settings first, then random ones.
        phase = 0;
        fed_items = 0;
        while (fed_items < RANDOM_ITEMS) begin
            if (fed_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 9;
                recv_idle_pct = 70;
            end else if (fed_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 70;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (phase < 6) begin
                k_data     = 11'(corner_k[phase]);
                count_data = 11'(corner_cnt[phase]);
            end else begin
                k_data     = 11'($urandom);
                count_data = ($urandom_range(0, 4) == 0) ? 11'($urandom)
                                                         : 11'($urandom_range(0, 80));
            end
            reconfigure(k_data, count_data);
            phase++;
            repeat ($urandom_range(1, 2)) ranking_round();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
